// ----- design/vth_pkg.sv -----
// ----------------------------------------------------------------------------
// vth_pkg
// Shared types and constants for the homogeneous vertex transform unit.
// ----------------------------------------------------------------------------
package vth_pkg;

  localparam int NCOMP  = 4;
  localparam int NREG   = NCOMP * NCOMP / 2;
  localparam int REG_W  = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;
  localparam int CW     = 32;
  // Rounded product width and magnitude width.
  localparam int PW     = 50;
  localparam int MW     = 49;
  // Fraction shift of the quotient plus one rounding bit.
  localparam int NSH    = 17;
  localparam int QW     = 34;
  localparam int FRAC   = 16;

  localparam logic [REG_W-1:0] CFG_RESET [NREG] = '{
    64'h0000_0001_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0000_0001_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  localparam logic [CW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic [NCOMP-1:0][CW-1:0] vec_t;
  typedef logic [NCOMP-1:0][NCOMP-1:0][CW-1:0] mat_t;
  typedef logic [NCOMP-1:0][PW-1:0] prodv_t;

  typedef struct packed {
    logic valid;
    logic divide;
  } ctl_t;

  typedef struct packed {
    logic [MW-1:0]  rem;
    logic [NSH-1:0] nsh;
    logic [QW-1:0]  quo;
  } lane_t;

  typedef lane_t [NCOMP-1:0] lanes_t;

  typedef struct packed {
    logic             dodiv;
    logic             zero;
    logic [NCOMP-1:0] neg;
    logic [NCOMP-1:0] ovf;
    vec_t             nd_out;
    logic             nd_sat;
    logic [MW-1:0]    den;
  } side_t;

endpackage

// ----- design/vertex_transform_homogenize_unit.sv -----
// ----------------------------------------------------------------------------
// vertex_transform_homogenize_unit
// Homogeneous 4x4 vertex transform with optional perspective divide.
// ----------------------------------------------------------------------------
// A point beat is taken on every cycle in which start is high; busy is never
// raised. Each point gives one result beat, marked by out_valid_o for a single
// cycle, after it passes the multiply and rounding registers, divide set-up
// stages A and B, the one-bit-per-stage divider and the rounding and saturation
// register. The receiver cannot stall the block, so it must take every result
// beat as it appears. The matrix may only be rewritten when no point is in
// flight.
module vertex_transform_homogenize_unit import vth_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CW-1:0]     pos_x_i,
  input  logic [CW-1:0]     pos_y_i,
  input  logic [CW-1:0]     pos_z_i,
  input  logic [CW-1:0]     pos_w_i,
  input  logic              divide_by_w_i,
  output logic              out_valid_o,
  output logic [CW-1:0]     out_x_o,
  output logic [CW-1:0]     out_y_o,
  output logic [CW-1:0]     out_z_o,
  output logic [CW-1:0]     out_w_o,
  output logic              zero_divisor_o,
  output logic              saturated_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready
);

  mat_t   mat;
  vec_t   pos;
  ctl_t   ctl_in, ctl_mac;
  prodv_t p;
  vec_t   res;

  assign busy          = 1'b0;
  assign ctl_in.valid  = start;
  assign ctl_in.divide = divide_by_w_i;
  assign pos[0]        = pos_x_i;
  assign pos[1]        = pos_y_i;
  assign pos[2]        = pos_z_i;
  assign pos[3]        = pos_w_i;

  vth_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat_o   (mat)
  );

  vth_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_in),
    .pos_i  (pos),
    .mat_i  (mat),
    .ctl_o  (ctl_mac),
    .p_o    (p)
  );

  vth_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_mac),
    .p_i     (p),
    .valid_o (out_valid_o),
    .out_o   (res),
    .zero_o  (zero_divisor_o),
    .sat_o   (saturated_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];
  assign out_w_o = res[3];

endmodule

// ----- design/vth_cfg.sv -----
// ----------------------------------------------------------------------------
// vth_cfg
// Register file for the transform matrix behind the configuration port.
// ----------------------------------------------------------------------------
module vth_cfg import vth_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output mat_t              mat_o
);

  logic [REG_W-1:0] regs_q [NREG];
  logic [IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pready = 1'b1;
  assign prdata = regs_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NREG; k++) regs_q[k] <= CFG_RESET[k];
    end else if (psel && penable && pwrite) begin
      regs_q[idx] <= pwdata;
    end
  end

  for (genvar r = 0; r < NCOMP; r++) begin : g_row
    for (genvar c = 0; c < NCOMP; c++) begin : g_col
      if (c % 2 == 0) begin : g_hi
        assign mat_o[r][c] = regs_q[(r*NCOMP+c)/2][REG_W-1:CW];
      end else begin : g_lo
        assign mat_o[r][c] = regs_q[(r*NCOMP+c)/2][CW-1:0];
      end
    end
  end

endmodule

// ----- design/vth_mac.sv -----
// ----------------------------------------------------------------------------
// vth_mac
// Vector by matrix multiply: products, pair sums, then final sum and rounding.
// ----------------------------------------------------------------------------
module vth_mac import vth_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  vec_t   pos_i,
  input  mat_t   mat_i,
  output ctl_t   ctl_o,
  output prodv_t p_o
);

  logic signed [2*CW-1:0] prod_q [NCOMP][NCOMP];
  logic signed [2*CW:0]   pair_q [NCOMP][2];
  logic signed [2*CW+1:0] sum    [NCOMP];
  prodv_t                 p_q;
  logic [2:0]             valid_q;
  logic [2:0]             div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], ctl_i.valid};
    end
  end

  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      sum[c] = (2*CW+2)'(pair_q[c][0]) + (2*CW+2)'(pair_q[c][1])
             + (2*CW+2)'(1 << (FRAC-1));
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= {div_q[1:0], ctl_i.divide};
    for (int r = 0; r < NCOMP; r++) begin
      for (int c = 0; c < NCOMP; c++) begin
        prod_q[r][c] <= $signed(pos_i[r]) * $signed(mat_i[r][c]);
      end
    end
    for (int c = 0; c < NCOMP; c++) begin
      pair_q[c][0] <= (2*CW+1)'(prod_q[0][c]) + (2*CW+1)'(prod_q[1][c]);
      pair_q[c][1] <= (2*CW+1)'(prod_q[2][c]) + (2*CW+1)'(prod_q[3][c]);
      p_q[c]       <= sum[c][FRAC+PW-1:FRAC];
    end
  end

  assign ctl_o.valid  = valid_q[2];
  assign ctl_o.divide = div_q[2];
  assign p_o          = p_q;

endmodule

// ----- design/vth_div_step.sv -----
// ----------------------------------------------------------------------------
// vth_div_step
// One restoring division step for all four lanes, registered.
// ----------------------------------------------------------------------------
module vth_div_step import vth_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  side_t  side_i,
  input  lanes_t lane_i,
  output logic   valid_o,
  output side_t  side_o,
  output lanes_t lane_o
);

  logic   valid_q;
  side_t  side_q;
  lanes_t lane_d, lane_q;
  logic [MW:0] t;
  logic        ge;

  always_comb begin
    t  = '0;
    ge = 1'b0;
    for (int c = 0; c < NCOMP; c++) begin
      t  = {lane_i[c].rem, lane_i[c].nsh[NSH-1]};
      ge = t >= {1'b0, side_i.den};
      lane_d[c].rem = ge ? MW'(t - {1'b0, side_i.den}) : t[MW-1:0];
      lane_d[c].nsh = {lane_i[c].nsh[NSH-2:0], 1'b0};
      lane_d[c].quo = {lane_i[c].quo[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign lane_o  = lane_q;

endmodule

// ----- design/vth_div.sv -----
// ----------------------------------------------------------------------------
// vth_div
// Perspective divide: operand set-up, pipelined restoring divider,
// rounding, saturation and result selection.
// ----------------------------------------------------------------------------
module vth_div import vth_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctl_t   ctl_i,
  input  prodv_t p_i,
  output logic   valid_o,
  output vec_t   out_o,
  output logic   zero_o,
  output logic   sat_o
);

  // Set-up stage A: magnitudes, signs and the undivided saturated results.
  logic                     va_q;
  side_t                    sa_d, sa_q;
  logic [NCOMP-1:0][MW-1:0] mag_d, mag_q;
  logic [PW-1:0]            negp;
  logic                     fits;

  always_comb begin
    sa_d        = '0;
    sa_d.zero   = ctl_i.divide && (p_i[NCOMP-1] == '0);
    sa_d.dodiv  = ctl_i.divide && (p_i[NCOMP-1] != '0);
    for (int c = 0; c < NCOMP; c++) begin
      negp      = ~p_i[c] + PW'(1);
      mag_d[c]  = p_i[c][PW-1] ? negp[MW-1:0] : p_i[c][MW-1:0];
      sa_d.neg[c] = p_i[c][PW-1] ^ p_i[NCOMP-1][PW-1];
      fits = (p_i[c][PW-1:CW-1] == '0) || (p_i[c][PW-1:CW-1] == '1);
      sa_d.nd_out[c] = fits ? p_i[c][CW-1:0] : (p_i[c][PW-1] ? SAT_NEG : SAT_POS);
      sa_d.nd_sat = sa_d.nd_sat | ~fits;
    end
    sa_d.den = mag_d[NCOMP-1];
  end

  always_ff @(posedge clk_i) begin
    sa_q  <= sa_d;
    mag_q <= mag_d;
  end

  // Set-up stage B: overflow check and initial partial remainder.
  logic   vb_q;
  side_t  sb_d, sb_q;
  lanes_t lb_d, lb_q;

  always_comb begin
    sb_d = sa_q;
    for (int c = 0; c < NCOMP; c++) begin
      sb_d.ovf[c]   = MW'(mag_q[c][MW-1:NSH]) >= sa_q.den;
      lb_d[c].rem   = MW'(mag_q[c][MW-1:NSH]);
      lb_d[c].nsh   = mag_q[c][NSH-1:0];
      lb_d[c].quo   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q <= sb_d;
    lb_q <= lb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= ctl_i.valid;
      vb_q <= va_q;
    end
  end

  // Division steps, one quotient bit per stage.
  logic   vs   [QW+1];
  side_t  ss   [QW+1];
  lanes_t ls   [QW+1];

  assign vs[0] = vb_q;
  assign ss[0] = sb_q;
  assign ls[0] = lb_q;

  for (genvar k = 0; k < QW; k++) begin : g_step
    vth_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vs[k]),
      .side_i  (ss[k]),
      .lane_i  (ls[k]),
      .valid_o (vs[k+1]),
      .side_o  (ss[k+1]),
      .lane_o  (ls[k+1])
    );
  end

  // Rounding, saturation and selection.
  logic           vf_q;
  vec_t           out_d, out_q;
  logic           zero_q, sat_d, sat_q;
  logic [QW:0]    qr;
  logic [QW-1:0]  q;
  logic           csat;
  side_t          sf;

  always_comb begin
    sf    = ss[QW];
    sat_d = sf.nd_sat;
    out_d = sf.nd_out;
    if (sf.dodiv) begin
      sat_d = 1'b0;
      for (int c = 0; c < NCOMP; c++) begin
        qr = {1'b0, ls[QW][c].quo} + (QW+1)'(1);
        q  = qr[QW:1];
        if (sf.neg[c]) begin
          csat     = sf.ovf[c] || (q > QW'(SAT_NEG));
          out_d[c] = csat ? SAT_NEG : (~q[CW-1:0] + CW'(1));
        end else begin
          csat     = sf.ovf[c] || (q > QW'(SAT_POS));
          out_d[c] = csat ? SAT_POS : q[CW-1:0];
        end
        sat_d = sat_d | csat;
      end
    end else begin
      qr   = '0;
      q    = '0;
      csat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= vs[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    zero_q <= sf.zero;
    sat_q  <= sat_d;
  end

  assign valid_o = vf_q;
  assign out_o   = out_q;
  assign zero_o  = zero_q;
  assign sat_o   = sat_q;

endmodule
